// ----- hw/rtl/trl_pkg.sv -----
// ----------------------------------------------------------------------------
// Trilateration package
// Shared types, register indexes and widths for the trilateration solver.
// ----------------------------------------------------------------------------
package trl_pkg;

	localparam int QuoW = 32;  // quotient bits resolved by the cell row
	localparam int DenW = 37;  // magnitude of the determinant
	localparam int NumW = 52;  // magnitude of a Cramer numerator

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t REG_ANCHOR0_X = 3'd0;
	localparam cfg_index_t REG_ANCHOR0_Y = 3'd1;
	localparam cfg_index_t REG_ANCHOR1_X = 3'd2;
	localparam cfg_index_t REG_ANCHOR1_Y = 3'd3;
	localparam cfg_index_t REG_ANCHOR2_X = 3'd4;
	localparam cfg_index_t REG_ANCHOR2_Y = 3'd5;

	typedef enum logic [1:0] {
		FIX_OK       = 2'd0,
		FIX_DET_ZERO = 2'd1,
		FIX_SAT      = 2'd2
	} fix_status_t;

	typedef struct packed {
		logic [14:0] dist0;
		logic [14:0] dist1;
		logic [14:0] dist2;
	} trl_in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [1:0]         fix_status;
	} trl_out_t;

	// State of one division lane as it travels along the cell row.
	typedef struct packed {
		logic [DenW-1:0] rem;
		logic [QuoW-1:0] num;
		logic [QuoW-1:0] quo;
		logic [DenW-1:0] den;
		logic            neg;
		logic            ovf;
	} trl_lane_t;

endpackage

// ----- hw/rtl/trl_div_cell.sv -----
// ----------------------------------------------------------------------------
// Division cell
// Resolves one quotient bit of a restoring division and passes the lane on.
// ----------------------------------------------------------------------------
module trl_div_cell import trl_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  trl_lane_t lane_i,
	output trl_lane_t lane_q
);

	logic [DenW:0]   trial;
	logic            ge;
	logic [DenW-1:0] rem_next;

	always_comb begin
		trial    = {lane_i.rem, lane_i.num[QuoW-1]};
		ge       = (trial >= {1'b0, lane_i.den});
		rem_next = ge ? DenW'(trial - {1'b0, lane_i.den}) : trial[DenW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q.rem <= rem_next;
			lane_q.num <= {lane_i.num[QuoW-2:0], 1'b0};
			lane_q.quo <= {lane_i.quo[QuoW-2:0], ge};
			lane_q.den <= lane_i.den;
			lane_q.neg <= lane_i.neg;
			lane_q.ovf <= lane_i.ovf;
		end
	end

endmodule

// ----- hw/rtl/trilateration_2d_three_anchors.sv -----
// Pipeline: 5 front stages, 32 division cells and 1 output register.
// Throughput: one item per cycle while out_ready does not stall the pipeline.
// The 32-cell quotient row is fully pipelined.
// Reset: arst_n clears anchor registers to zero and all valid bits at once.
// ----------------------------------------------------------------------------
// Planar trilateration solver
// Solves two linear equations built from three anchors by Cramer's rule.
// ----------------------------------------------------------------------------
module trilateration_2d_three_anchors import trl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  cfg_index_t cfg_index,
	input  logic [15:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  trl_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output trl_out_t   out_data
);

	// The whole pipeline moves together. The output register is its last
	// stage, so a new transfer is taken whenever that register is empty or
	// is being emptied in the same cycle.
	logic adv;

	logic signed [15:0] ax0_q, ay0_q, ax1_q, ay1_q, ax2_q, ay2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax0_q <= '0;
			ay0_q <= '0;
			ax1_q <= '0;
			ay1_q <= '0;
			ax2_q <= '0;
			ay2_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ANCHOR0_X: ax0_q <= cfg_data;
				REG_ANCHOR0_Y: ay0_q <= cfg_data;
				REG_ANCHOR1_X: ax1_q <= cfg_data;
				REG_ANCHOR1_Y: ay1_q <= cfg_data;
				REG_ANCHOR2_X: ax2_q <= cfg_data;
				REG_ANCHOR2_Y: ay2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: squares of the distances and anchors, and the coefficients
	// A and B, which are twice the coordinate differences.
	logic signed [16:0] dx0, dy0, dx1, dy1;
	logic [29:0]        dsq0_s1, dsq1_s1, dsq2_s1;
	logic signed [31:0] sx0_s1, sy0_s1, sx1_s1, sy1_s1, sx2_s1, sy2_s1;
	logic signed [17:0] a0_s1, b0_s1, a1_s1, b1_s1;
	logic               v_s1;

	assign dx0 = 17'(ax1_q) - 17'(ax0_q);
	assign dy0 = 17'(ay1_q) - 17'(ay0_q);
	assign dx1 = 17'(ax2_q) - 17'(ax1_q);
	assign dy1 = 17'(ay2_q) - 17'(ay1_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			dsq0_s1 <= 30'(in_data.dist0) * 30'(in_data.dist0);
			dsq1_s1 <= 30'(in_data.dist1) * 30'(in_data.dist1);
			dsq2_s1 <= 30'(in_data.dist2) * 30'(in_data.dist2);
			sx0_s1  <= 32'(ax0_q) * 32'(ax0_q);
			sy0_s1  <= 32'(ay0_q) * 32'(ay0_q);
			sx1_s1  <= 32'(ax1_q) * 32'(ax1_q);
			sy1_s1  <= 32'(ay1_q) * 32'(ay1_q);
			sx2_s1  <= 32'(ax2_q) * 32'(ax2_q);
			sy2_s1  <= 32'(ay2_q) * 32'(ay2_q);
			a0_s1   <= {dx0, 1'b0};
			b0_s1   <= {dy0, 1'b0};
			a1_s1   <= {dx1, 1'b0};
			b1_s1   <= {dy1, 1'b0};
		end
	end

	// Stage 2: right-hand sides C and the two determinant products.
	logic signed [33:0] c0_s2, c1_s2;
	logic signed [17:0] a0_s2, b0_s2, a1_s2, b1_s2;
	logic signed [35:0] pab_s2, pba_s2;
	logic               v_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			c0_s2  <= $signed({4'b0, dsq0_s1}) - $signed({4'b0, dsq1_s1})
				+ 34'(sx1_s1) - 34'(sx0_s1) + 34'(sy1_s1) - 34'(sy0_s1);
			c1_s2  <= $signed({4'b0, dsq1_s1}) - $signed({4'b0, dsq2_s1})
				+ 34'(sx2_s1) - 34'(sx1_s1) + 34'(sy2_s1) - 34'(sy1_s1);
			a0_s2  <= a0_s1;
			b0_s2  <= b0_s1;
			a1_s2  <= a1_s1;
			b1_s2  <= b1_s1;
			pab_s2 <= 36'(a0_s1) * 36'(b1_s1);
			pba_s2 <= 36'(a1_s1) * 36'(b0_s1);
		end
	end

	// Stage 3: determinant, and the four numerator products.
	logic signed [37:0] det_s3;
	logic signed [51:0] px1_s3, px2_s3, py1_s3, py2_s3;
	logic               v_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s3 <= 38'(pab_s2) - 38'(pba_s2);
			px1_s3 <= 52'(c0_s2) * 52'(b1_s2);
			px2_s3 <= 52'(c1_s2) * 52'(b0_s2);
			py1_s3 <= 52'(a0_s2) * 52'(c1_s2);
			py2_s3 <= 52'(a1_s2) * 52'(c0_s2);
		end
	end

	// Stage 4: the two numerators.
	logic signed [37:0] det_s4;
	logic signed [52:0] nx_s4, ny_s4;
	logic               v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= det_s3;
			nx_s4  <= 53'(px1_s3) - 53'(px2_s3);
			ny_s4  <= 53'(py1_s3) - 53'(py2_s3);
		end
	end

	// Stage 5: magnitudes and signs. A quotient of 2^32 or more in magnitude
	// saturates whatever its sign, so it is flagged here and the cell row
	// only needs to resolve the low 32 quotient bits. The upper numerator
	// bits then start as the partial remainder, known to be below the
	// divisor.
	logic [52:0]     nxa, nya;
	logic [37:0]     da;
	logic [NumW-1:0] nxm, nym;
	logic [DenW-1:0] dm;
	trl_lane_t       lx_s5, ly_s5;
	logic            dz_s5;
	logic            v_s5;

	always_comb begin
		nxa = nx_s4[52] ? 53'(-nx_s4) : 53'(nx_s4);
		nya = ny_s4[52] ? 53'(-ny_s4) : 53'(ny_s4);
		da  = det_s4[37] ? 38'(-det_s4) : 38'(det_s4);
		nxm = nxa[NumW-1:0];
		nym = nya[NumW-1:0];
		dm  = da[DenW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lx_s5.rem <= DenW'(nxm[NumW-1:QuoW]);
			lx_s5.num <= nxm[QuoW-1:0];
			lx_s5.quo <= '0;
			lx_s5.den <= dm;
			lx_s5.neg <= nx_s4[52] ^ det_s4[37];
			lx_s5.ovf <= {(DenW+QuoW-NumW)'(0), nxm} >= {dm, QuoW'(0)};
			ly_s5.rem <= DenW'(nym[NumW-1:QuoW]);
			ly_s5.num <= nym[QuoW-1:0];
			ly_s5.quo <= '0;
			ly_s5.den <= dm;
			ly_s5.neg <= ny_s4[52] ^ det_s4[37];
			ly_s5.ovf <= {(DenW+QuoW-NumW)'(0), nym} >= {dm, QuoW'(0)};
			dz_s5     <= (det_s4 == '0);
		end
	end

	// Division rows: each stage resolves one quotient bit for x and one for y.
	// The zero-determinant flag and the valid bit travel alongside.
	trl_lane_t lx_c [QuoW+1];
	trl_lane_t ly_c [QuoW+1];
	logic      dz_c_q [QuoW+1];
	logic      v_c_q  [QuoW+1];

	assign lx_c[0]   = lx_s5;
	assign ly_c[0]   = ly_s5;
	assign dz_c_q[0] = dz_s5;
	assign v_c_q[0]  = v_s5;

	for (genvar k = 0; k < QuoW; k++) begin : g_cell
		trl_div_cell u_cell_x (
			.clk    (clk),
			.en     (adv),
			.lane_i (lx_c[k]),
			.lane_q (lx_c[k+1])
		);
		trl_div_cell u_cell_y (
			.clk    (clk),
			.en     (adv),
			.lane_i (ly_c[k]),
			.lane_q (ly_c[k+1])
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				dz_c_q[k+1] <= dz_c_q[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_c_q[k+1] <= 1'b0;
			end else if (adv) begin
				v_c_q[k+1] <= v_c_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Output stage: apply the sign and clamp each coordinate on its own.
	// A positive quotient may reach 2^31 - 1 and a negative one -2^31.
	function automatic logic [32:0] finish(input trl_lane_t l);
		logic sat;
		sat = l.ovf || (l.neg ? (l.quo > 32'h8000_0000) : l.quo[QuoW-1]);
		if (sat) begin
			return {1'b1, l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
		end
		return {1'b0, l.neg ? 32'(-l.quo) : l.quo};
	endfunction

	logic [32:0] fx, fy;
	logic        out_valid_q;
	trl_out_t    out_data_q;

	assign fx = finish(lx_c[QuoW]);
	assign fy = finish(ly_c[QuoW]);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dz_c_q[QuoW]) begin
				out_data_q.pos_x      <= '0;
				out_data_q.pos_y      <= '0;
				out_data_q.fix_status <= FIX_DET_ZERO;
			end else begin
				out_data_q.pos_x      <= fx[31:0];
				out_data_q.pos_y      <= fy[31:0];
				out_data_q.fix_status <= (fx[32] || fy[32]) ? FIX_SAT : FIX_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_c_q[QuoW];
		end
	end

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
